// ----- rtl/soa_pkg.sv -----
// Shared constants and types of the slab object allocator.
package soa_pkg;

  localparam int POOL_SLABS   = 16;
  localparam int PAGE_BYTES   = 4096;
  localparam int HEADER_BYTES = 32;
  localparam int MAX_SLOTS    = 508;

  localparam int SLAB_W  = $clog2(POOL_SLABS);
  localparam int SLOT_W  = $clog2(MAX_SLOTS + 1);
  localparam int CNT_W   = 9;
  localparam int PAGE_W  = $clog2(PAGE_BYTES);
  localparam int MEM_W   = $clog2(POOL_SLABS * MAX_SLOTS);
  localparam int HDR     = ((HEADER_BYTES + 7) / 8) * 8;
  localparam int SLABS_W = 5;
  localparam int OBJ_W   = 13;

  localparam logic [SLOT_W-1:0] NO_SLOT = SLOT_W'(MAX_SLOTS);

  localparam logic [2:0] OP_ALLOC   = 3'd0;
  localparam logic [2:0] OP_FREE    = 3'd1;
  localparam logic [2:0] OP_REAP    = 3'd2;
  localparam logic [2:0] OP_STATS   = 3'd3;
  localparam logic [2:0] OP_DESTROY = 3'd4;

  localparam logic [2:0] ST_OK        = 3'd0;
  localparam logic [2:0] ST_NO_PAGE   = 3'd1;
  localparam logic [2:0] ST_NOT_OWNED = 3'd2;
  localparam logic [2:0] ST_DOUBLE    = 3'd3;
  localparam logic [2:0] ST_MISALIGN  = 3'd4;

  localparam logic CFG_OSIZE     = 1'b0;
  localparam logic CFG_POOL_BASE = 1'b1;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic start;     // latch the item and clear the result
    logic busy;      // an item is in work
  } soa_cmd_t;

  // Status returned from the datapath.
  typedef struct packed {
    logic done;
  } soa_sts_t;

endpackage

// ----- rtl/slab_object_allocator.sv -----
// Slab object allocator: one object cache over a fixed pool of page slabs.
//
// The in_ channel takes one item per operation (alloc, free, reap, stats,
// destroy); tdata holds the opcode in bits 2:0 and the address in 50:3.
// The out_ channel returns exactly one item per input item carrying status,
// object address, slab and object counts and both running counters.
// Items are handled one at a time. An alloc from the partial slab pops its
// free list; claiming a fresh page first writes the slab's free list, one slot
// a cycle, and filling the slab adds a search for another partial slab. Free
// divides by the slot size with one subtraction a cycle and then reads and
// checks the slot. Stats walks the slab order one slab a cycle; reap walks
// it too and adds a search each time it releases the partial slab.
// After reset, or a write of the object size register, the slots-per-slab
// count is recomputed by repeated subtraction before the first item is worked
// on. The result waits in its register while out_tready is low; no new item is
// taken until it has gone, and in_tready returns in the cycle after that. Write
// configuration through cfg_ only while idle; the block does not enforce it.
module slab_object_allocator
  import soa_pkg::*;
(
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_tvalid,
  output logic         in_tready,
  input  logic [55:0]  in_tdata,   // opcode[2:0], address[50:3]
  output logic         out_tvalid,
  input  logic         out_tready,
  // status[2:0], object_address[50:3], slab_count[55:51], objects_used[68:56],
  // objects_total[81:69], alloc_total[145:82], free_total[209:146]
  output logic [215:0] out_tdata,
  input  logic         cfg_we,
  input  logic         cfg_index,
  input  logic [47:0]  cfg_data
);

  soa_cmd_t cmd;
  soa_sts_t sts;
  logic [2:0] st;
  logic [47:0] oa;
  logic [SLABS_W-1:0] sc;
  logic [OBJ_W-1:0] ou, ot;
  logic [63:0] at, ft;

  soa_ctrl u_ctrl (
    .clk(clk), .rst_n(rst_n), .in_tvalid(in_tvalid), .in_tready(in_tready),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .cmd(cmd), .sts(sts)
  );

  soa_dp u_dp (
    .clk(clk), .rst_n(rst_n), .cmd(cmd), .sts(sts),
    .in_opcode(in_tdata[2:0]), .in_address(in_tdata[50:3]),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .out_status(st), .out_object_address(oa), .out_slab_count(sc),
    .out_used_objs(ou), .out_total_objs(ot),
    .out_alloc_total(at), .out_free_total(ft)
  );

  // Pack the result fields.
  assign out_tdata = {6'd0, ft, at, ot, ou, sc, oa, st};

endmodule

// ----- rtl/soa_ram.sv -----
// Generic simple dual-port RAM (one write port, one read port) with a registered read.
module soa_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write, then read registered.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ----- rtl/soa_ctrl.sv -----
// Controller: accepts an item, runs the datapath, hands the result over.
module soa_ctrl
  import soa_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_tvalid,
  output logic     in_tready,
  output logic     out_tvalid,
  input  logic     out_tready,
  output soa_cmd_t cmd,
  input  soa_sts_t sts
);

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_RUN  = 2'd1;
  localparam logic [1:0] S_OUT  = 2'd2;

  logic [1:0] state_r, state_nxt;

  assign in_tready  = (state_r == S_IDLE);
  assign out_tvalid = (state_r == S_OUT);
  assign cmd.start  = in_tvalid && in_tready;
  assign cmd.busy   = (state_r == S_RUN);

  // Next state.
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: if (in_tvalid) state_nxt = S_RUN;
      S_RUN:  if (sts.done) state_nxt = S_OUT;
      S_OUT:  if (out_tready) state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

`ifndef NO_ASSERTIONS
  a_no_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.busy |-> !in_tready) else $error("accept while busy");
  a_out_after_run: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_tvalid) |-> $past(cmd.busy)) else $error("result without work");
  a_done_leaves: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.busy && sts.done) |=> out_tvalid) else $error("done lost");
`endif

endmodule

// ----- rtl/soa_dp.sv -----
// Datapath: slab tables, free-list memory and the step sequencer of each operation.
module soa_dp
  import soa_pkg::*;
(
  input  logic           clk,
  input  logic           rst_n,
  input  soa_cmd_t       cmd,
  output soa_sts_t       sts,
  input  logic [2:0]     in_opcode,
  input  logic [47:0]    in_address,
  input  logic           cfg_we,
  input  logic           cfg_index,
  input  logic [47:0]    cfg_data,
  output logic [2:0]     out_status,
  output logic [47:0]    out_object_address,
  output logic [SLABS_W-1:0] out_slab_count,
  output logic [OBJ_W-1:0]   out_used_objs,
  output logic [OBJ_W-1:0]   out_total_objs,
  output logic [63:0]    out_alloc_total,
  output logic [63:0]    out_free_total
);

  // Sequencer steps.
  localparam logic [3:0] P_DISP  = 4'd0;
  localparam logic [3:0] P_INIT  = 4'd1;  // fill a fresh slab's list
  localparam logic [3:0] P_POP   = 4'd2;  // take the head slot whose next pointer is read
  localparam logic [3:0] P_POPW  = 4'd3;
  localparam logic [3:0] P_POPD  = 4'd4;
  localparam logic [3:0] P_SRCH  = 4'd5;  // partial slab search
  localparam logic [3:0] P_FDIV  = 4'd6;  // slot index division
  localparam logic [3:0] P_FRD   = 4'd7;
  localparam logic [3:0] P_FRDW  = 4'd8;
  localparam logic [3:0] P_FCHK  = 4'd9;
  localparam logic [3:0] P_REAP  = 4'd10;
  localparam logic [3:0] P_STAT  = 4'd11;
  localparam logic [3:0] P_MUL   = 4'd12;
  localparam logic [3:0] P_DONE  = 4'd13;
  localparam logic [3:0] P_SCNT  = 4'd14;

  localparam int ORD_W = SLAB_W + 1;
  localparam int FREE_BITS = SLOT_W + 1;

  // Configuration.
  logic [11:0] osize_r;
  logic [47:0] base_r;
  logic [PAGE_W:0] sbytes;
  logic [SLOT_W-1:0] per_r;

  // Slab tables.
  logic [POOL_SLABS-1:0] live_r;
  logic [CNT_W-1:0]  used_r [POOL_SLABS];
  logic [SLOT_W-1:0] head_r [POOL_SLABS];
  logic [SLAB_W-1:0] order_r [POOL_SLABS];
  logic [ORD_W-1:0]  olen_r;
  logic [ORD_W-1:0]  part_r;
  logic [63:0] acnt_r, fcnt_r;

  // Work registers.
  logic [3:0]  ph_r;
  logic [2:0]  op_r;
  logic [47:0] addr_r;
  logic [SLAB_W-1:0] pg_r;
  logic [SLOT_W-1:0] idx_r;
  logic [ORD_W-1:0]  i_r;
  logic [PAGE_W-1:0] rem_r;
  logic [SLOT_W-1:0] quo_r;
  logic [OBJ_W-1:0]  acc_r;
  logic [OBJ_W-1:0]  mul_r;
  logic [ORD_W-1:0]  cnt_r;
  logic        geo_busy_r;
  logic [PAGE_W:0] geo_rem_r;
  logic [SLOT_W-1:0] geo_q_r;

  // Free-list memory, next pointer plus free flag per slot.
  logic              mwe;
  logic [MEM_W-1:0]  mwaddr, mraddr;
  logic [FREE_BITS-1:0] mwdata, mrdata;

  soa_ram #(.WIDTH(FREE_BITS), .DEPTH(POOL_SLABS * MAX_SLOTS)) u_slots (
    .clk(clk), .we(mwe), .waddr(mwaddr), .wdata(mwdata),
    .raddr(mraddr), .rdata(mrdata)
  );

  function automatic logic [MEM_W-1:0] slot_at(input logic [SLAB_W-1:0] p,
                                               input logic [SLOT_W-1:0] s);
    logic [MEM_W+SLOT_W-1:0] t;
    t = (MEM_W + SLOT_W)'(p) * (MEM_W + SLOT_W)'(MAX_SLOTS) + (MEM_W + SLOT_W)'(s);
    return t[MEM_W-1:0];
  endfunction

  // Rounded slot size; one bit wider than the page offset so that sizes
  // near a whole page round up without wrapping.
  always_comb begin
    sbytes = (osize_r < 12'd8) ? (PAGE_W+1)'(8) : {1'b0, osize_r};
    sbytes = (sbytes + (PAGE_W+1)'(7)) & ~(PAGE_W+1)'(7);
  end

  // Lowest free page.
  logic [ORD_W-1:0] free_pg;
  always_comb begin
    free_pg = ORD_W'(POOL_SLABS);
    for (int k = POOL_SLABS - 1; k >= 0; k--) begin
      if (!live_r[k]) free_pg = ORD_W'(k);
    end
  end

  // Free address decode.
  logic [48:0] off;
  logic [47:0] pgn;
  logic [PAGE_W-1:0] pg_off;
  assign off    = {1'b0, addr_r} - {1'b0, base_r};
  assign pgn    = off[47:0] >> PAGE_W;
  assign pg_off = off[PAGE_W-1:0];

  logic [SLAB_W-1:0] cur;
  assign cur = order_r[i_r[SLAB_W-1:0]];

  assign sts.done = (ph_r == P_DONE);

  // Result address: the slot offset product is only slot index by slot size wide.
  logic [SLOT_W+PAGE_W:0] slot_off;
  logic [47:0] obj_addr;
  assign slot_off = (SLOT_W+PAGE_W+1)'(idx_r) * (SLOT_W+PAGE_W+1)'(sbytes);
  assign obj_addr = base_r + (48'(pg_r) << PAGE_W) + 48'(HDR) + 48'(slot_off);

  always_comb begin
    mwe    = 1'b0;
    mwaddr = slot_at(pg_r, idx_r);
    mwdata = '0;
    mraddr = slot_at(pg_r, idx_r);
    if (ph_r == P_INIT) begin
      mwe = 1'b1;
      mwdata = {1'b1, (idx_r + 1'b1 < per_r) ? SLOT_W'(idx_r + 1'b1) : NO_SLOT};
    end else if (ph_r == P_POPD) begin
      mwe = 1'b1;
      mwdata = {1'b0, mrdata[SLOT_W-1:0]};
    end else if (ph_r == P_FCHK && !mrdata[SLOT_W]) begin
      mwe = 1'b1;
      mwdata = {1'b1, head_r[pg_r]};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ph_r <= P_DISP;
      osize_r <= 12'd8;
      base_r <= '0;
      live_r <= '0;
      olen_r <= '0;
      part_r <= ORD_W'(POOL_SLABS);
      acnt_r <= '0;
      fcnt_r <= '0;
      geo_busy_r <= 1'b1;
      geo_rem_r <= (PAGE_W+1)'(PAGE_BYTES - HDR);
      geo_q_r <= '0;
      per_r <= '0;
      for (int k = 0; k < POOL_SLABS; k++) used_r[k] <= '0;
    end else begin
      // Slots per slab, by repeated subtraction after reset or a size change.
      if (geo_busy_r) begin
        if (geo_rem_r >= sbytes && geo_q_r < NO_SLOT) begin
          geo_rem_r <= geo_rem_r - sbytes;
          geo_q_r <= geo_q_r + 1'b1;
        end else begin
          per_r <= geo_q_r;
          geo_busy_r <= 1'b0;
        end
      end
      if (cfg_we) begin
        if (cfg_index == CFG_OSIZE) begin
          osize_r <= cfg_data[11:0];
          live_r <= '0;
          olen_r <= '0;
          part_r <= ORD_W'(POOL_SLABS);
          acnt_r <= '0;
          fcnt_r <= '0;
          geo_busy_r <= 1'b1;
          geo_rem_r <= (PAGE_W+1)'(PAGE_BYTES - HDR);
          geo_q_r <= '0;
          for (int k = 0; k < POOL_SLABS; k++) used_r[k] <= '0;
        end else begin
          base_r <= cfg_data;
        end
      end
      if (cmd.start) begin
        op_r <= in_opcode;
        addr_r <= in_address;
        out_status <= ST_OK;
        out_object_address <= '0;
        out_slab_count <= '0;
        out_used_objs <= '0;
        out_total_objs <= '0;
        i_r <= '0;
        acc_r <= '0;
        cnt_r <= '0;
        ph_r <= P_DISP;
      end else if (cmd.busy && !geo_busy_r) begin
        case (ph_r)
          P_DISP: begin
            case (op_r)
              OP_ALLOC: begin
                if (per_r == '0) begin
                  out_status <= ST_NO_PAGE; ph_r <= P_DONE;
                end else if (part_r < ORD_W'(POOL_SLABS)) begin
                  pg_r <= part_r[SLAB_W-1:0]; ph_r <= P_POP;
                end else if (free_pg >= ORD_W'(POOL_SLABS)) begin
                  out_status <= ST_NO_PAGE; ph_r <= P_DONE;
                end else begin
                  pg_r <= free_pg[SLAB_W-1:0];
                  live_r[free_pg[SLAB_W-1:0]] <= 1'b1;
                  used_r[free_pg[SLAB_W-1:0]] <= '0;
                  head_r[free_pg[SLAB_W-1:0]] <= '0;
                  order_r[0] <= free_pg[SLAB_W-1:0];
                  for (int k = 1; k < POOL_SLABS; k++) order_r[k] <= order_r[k-1];
                  olen_r <= olen_r + 1'b1;
                  part_r <= free_pg;
                  idx_r <= '0;
                  ph_r <= P_INIT;
                end
              end
              OP_FREE: begin
                if (addr_r == '0 || off[48] || pgn >= 48'(POOL_SLABS) ||
                    !live_r[pgn[SLAB_W-1:0]]) begin
                  out_status <= ST_NOT_OWNED; ph_r <= P_DONE;
                end else if (pg_off < PAGE_W'(HDR)) begin
                  out_status <= ST_MISALIGN; ph_r <= P_DONE;
                end else begin
                  pg_r <= pgn[SLAB_W-1:0];
                  rem_r <= pg_off - PAGE_W'(HDR);
                  quo_r <= '0;
                  ph_r <= P_FDIV;
                end
              end
              OP_REAP: ph_r <= P_REAP;
              OP_STATS: ph_r <= P_STAT;
              OP_DESTROY: begin
                live_r <= '0;
                for (int k = 0; k < POOL_SLABS; k++) used_r[k] <= '0;
                olen_r <= '0;
                part_r <= ORD_W'(POOL_SLABS);
                ph_r <= P_DONE;
              end
              default: ph_r <= P_DONE;
            endcase
          end
          P_INIT: begin
            if (idx_r + 1'b1 >= per_r) begin
              idx_r <= head_r[pg_r]; ph_r <= P_POP;
            end else begin
              idx_r <= idx_r + 1'b1;
            end
          end
          P_POP: begin
            idx_r <= head_r[pg_r];
            ph_r <= (head_r[pg_r] == NO_SLOT) ? P_DONE : P_POPW;
            if (head_r[pg_r] == NO_SLOT) out_status <= ST_NO_PAGE;
          end
          P_POPW: ph_r <= P_POPD;
          P_POPD: begin
            head_r[pg_r] <= mrdata[SLOT_W-1:0];
            used_r[pg_r] <= used_r[pg_r] + 1'b1;
            acnt_r <= acnt_r + 1'b1;
            out_object_address <= obj_addr;
            i_r <= '0;
            if (mrdata[SLOT_W-1:0] == NO_SLOT && part_r == ORD_W'(pg_r)) begin
              part_r <= ORD_W'(POOL_SLABS);
              ph_r <= P_SRCH;
            end else begin
              ph_r <= P_DONE;
            end
          end
          P_SRCH: begin
            if (i_r >= olen_r) begin
              ph_r <= (op_r == OP_REAP) ? P_REAP : P_DONE;
            end else if (head_r[cur] != NO_SLOT) begin
              part_r <= ORD_W'(cur);
              ph_r <= (op_r == OP_REAP) ? P_REAP : P_DONE;
            end else begin
              i_r <= i_r + 1'b1;
            end
            if (op_r == OP_REAP && (i_r >= olen_r || head_r[cur] != NO_SLOT))
              i_r <= cnt_r;
          end
          P_FDIV: begin
            if ({1'b0, rem_r} >= sbytes) begin
              rem_r <= rem_r - sbytes[PAGE_W-1:0];
              quo_r <= quo_r + 1'b1;
            end else if (rem_r != '0 || quo_r >= per_r) begin
              out_status <= ST_MISALIGN; ph_r <= P_DONE;
            end else begin
              idx_r <= quo_r; ph_r <= P_FRD;
            end
          end
          P_FRD: ph_r <= P_FRDW;
          P_FRDW: ph_r <= P_FCHK;
          P_FCHK: begin
            if (mrdata[SLOT_W]) begin
              out_status <= ST_DOUBLE;
            end else begin
              head_r[pg_r] <= idx_r;
              if (used_r[pg_r] != '0) used_r[pg_r] <= used_r[pg_r] - 1'b1;
              fcnt_r <= fcnt_r + 1'b1;
              if (head_r[pg_r] == NO_SLOT) part_r <= ORD_W'(pg_r);
            end
            ph_r <= P_DONE;
          end
          P_REAP: begin
            // i_r walks the order; cnt_r holds the resume point after a search.
            if (i_r >= olen_r) begin
              ph_r <= P_DONE;
            end else if (used_r[cur] == '0) begin
              for (int k = 0; k < POOL_SLABS - 1; k++)
                if (ORD_W'(k) >= i_r) order_r[k] <= order_r[k+1];
              olen_r <= olen_r - 1'b1;
              live_r[cur] <= 1'b0;
              out_slab_count <= out_slab_count + 1'b1;
              if (part_r == ORD_W'(cur)) begin
                part_r <= ORD_W'(POOL_SLABS);
                cnt_r <= i_r;
                i_r <= '0;
                ph_r <= P_SRCH;
              end
            end else begin
              i_r <= i_r + 1'b1;
            end
          end
          P_STAT: begin
            if (i_r >= olen_r) begin
              out_slab_count <= SLABS_W'(olen_r);
              out_used_objs <= acc_r;
              mul_r <= OBJ_W'(olen_r) * OBJ_W'(per_r);
              ph_r <= P_MUL;
            end else begin
              acc_r <= acc_r + OBJ_W'(used_r[cur]);
              i_r <= i_r + 1'b1;
            end
          end
          P_MUL: begin
            out_total_objs <= mul_r;
            ph_r <= P_DONE;
          end
          P_DONE: ph_r <= P_SCNT;
          default: ph_r <= P_DONE;
        endcase
      end
    end
  end

  assign out_alloc_total = acnt_r;
  assign out_free_total  = fcnt_r;

`ifndef NO_ASSERTIONS
  a_olen_range: assert property (@(posedge clk) disable iff (!rst_n)
    olen_r <= ORD_W'(POOL_SLABS)) else $error("order overflow");
  a_part_live: assert property (@(posedge clk) disable iff (!rst_n)
    (part_r < ORD_W'(POOL_SLABS)) |-> live_r[part_r[SLAB_W-1:0]])
    else $error("partial slab not live");
  a_olen_count: assert property (@(posedge clk) disable iff (!rst_n)
    32'(olen_r) == $countones(live_r)) else $error("order length mismatch");
`endif

endmodule

// ----- dv/slab_object_allocator_tb.sv -----
// Self-checking testbench for the slab object allocator with a built-in prediction of slab state.
module slab_object_allocator_tb;
  import soa_pkg::*;

  localparam int IDLE_LIMIT = 8000;
  localparam logic [63:0] ADDR_MASK = 64'hFFFF_FFFF_FFFF;

  typedef enum logic [1:0] {ADDR_FIXED, ADDR_LIVE, ADDR_NOISE} addr_kind_t;

  typedef struct {
    logic [2:0]  op;
    logic [47:0] addr;
    addr_kind_t  kind;
  } op_item_t;

  typedef struct packed {
    logic [63:0] free_total;
    logic [63:0] alloc_total;
    logic [12:0] objects_total;
    logic [12:0] objects_used;
    logic [4:0]  slab_count;
    logic [47:0] object_address;
    logic [2:0]  status;
  } alloc_result_t;

  logic         clk = 1'b0;
  logic         rst_n = 1'b0;
  logic         in_tvalid = 1'b0;
  logic         in_tready;
  logic [55:0]  in_tdata = '0;   // opcode[2:0], address[50:3]
  logic         out_tvalid;
  logic         out_tready = 1'b0;
  // status, object_address, slab_count, objects_used, objects_total, alloc_total, free_total
  logic [215:0] out_tdata;
  logic         cfg_we = 1'b0;
  logic         cfg_index = 1'b0;
  logic [47:0]  cfg_data = '0;

  slab_object_allocator uut (.*);

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // Mirror of the allocator state.
  logic [11:0] req_bytes;
  logic [47:0] base_addr;
  logic        slab_live_m [POOL_SLABS];
  logic [8:0]  slab_used_m [POOL_SLABS];
  logic [9:0]  free_head_m [POOL_SLABS];
  logic [9:0]  next_slot_m [POOL_SLABS*MAX_SLOTS];
  logic        slot_free_m [POOL_SLABS*MAX_SLOTS];
  logic [3:0]  order_m [POOL_SLABS];
  int          order_len;
  int          partial_m;
  logic [63:0] allocs_done, frees_done;
  logic [47:0] live_objs[$];
  logic [47:0] freed_objs[$];

  op_item_t      pending_ops[$];
  alloc_result_t expected_results[$];
  int errors = 0, accepted = 0, results = 0;
  int status_seen [8];
  logic hold_sender = 1'b0;
  logic long_stall_req = 1'b0;

  function automatic int slot_size();
    int s;
    s = req_bytes;
    if (s < 8) s = 8;
    return (s + 7) & ~7;
  endfunction

  function automatic int slots_in_slab();
    int n;
    n = (PAGE_BYTES - HDR) / slot_size();
    return (n > MAX_SLOTS) ? MAX_SLOTS : n;
  endfunction

  function automatic int first_with_room();
    for (int i = 0; i < order_len; i++)
      if (free_head_m[order_m[i]] != NO_SLOT) return order_m[i];
    return POOL_SLABS;
  endfunction

  function automatic void drop_slabs();
    for (int i = 0; i < POOL_SLABS; i++) begin
      slab_live_m[i] = 1'b0;
      slab_used_m[i] = '0;
    end
    order_len = 0;
    partial_m = POOL_SLABS;
    live_objs.delete();
    freed_objs.delete();
  endfunction

  function automatic void remove_live(logic [47:0] a);
    for (int i = 0; i < live_objs.size(); i++)
      if (live_objs[i] == a) begin
        live_objs.delete(i);
        return;
      end
  endfunction

  // Alloc: pop the partial slab's free list, claiming a fresh page when needed.
  function automatic logic [2:0] model_alloc(output logic [47:0] a);
    int per, p, idx;
    logic [63:0] full;
    per = slots_in_slab();
    a = '0;
    if (per == 0) return ST_NO_PAGE;
    p = partial_m;
    if (p >= POOL_SLABS) begin
      for (p = 0; p < POOL_SLABS && slab_live_m[p]; p++) ;
      if (p >= POOL_SLABS) return ST_NO_PAGE;
      slab_live_m[p] = 1'b1;
      slab_used_m[p] = '0;
      free_head_m[p] = '0;
      for (int i = 0; i < per; i++) begin
        next_slot_m[p*MAX_SLOTS+i] = (i + 1 < per) ? 10'(i + 1) : 10'(NO_SLOT);
        slot_free_m[p*MAX_SLOTS+i] = 1'b1;
      end
      for (int i = order_len; i > 0; i--) order_m[i] = order_m[i-1];
      order_m[0] = 4'(p);
      order_len++;
      partial_m = p;
    end
    idx = free_head_m[p];
    if (idx >= MAX_SLOTS) return ST_NO_PAGE;
    free_head_m[p] = next_slot_m[p*MAX_SLOTS+idx];
    slot_free_m[p*MAX_SLOTS+idx] = 1'b0;
    slab_used_m[p] = slab_used_m[p] + 9'd1;
    allocs_done++;
    if (free_head_m[p] == NO_SLOT && partial_m == p) partial_m = first_with_room();
    full = 64'(base_addr) + 64'(p) * PAGE_BYTES + HDR + 64'(idx) * slot_size();
    a = full[47:0];
    live_objs.push_back(a);
    return ST_OK;
  endfunction

  // Free: ownership, alignment and double-free checks, then push back.
  function automatic logic [2:0] model_free(logic [47:0] a);
    logic [63:0] off, page, in_page;
    int s, idx, k;
    logic had_no_room;
    s = slot_size();
    if (a == 0 || a < base_addr) return ST_NOT_OWNED;
    off = 64'(a) - 64'(base_addr);
    page = off / PAGE_BYTES;
    if (page >= POOL_SLABS) return ST_NOT_OWNED;
    if (!slab_live_m[page]) return ST_NOT_OWNED;
    in_page = off % PAGE_BYTES;
    if (in_page < HDR || (in_page - HDR) % s != 0) return ST_MISALIGN;
    if ((in_page - HDR) / s >= slots_in_slab()) return ST_MISALIGN;
    idx = int'((in_page - HDR) / s);
    k = int'(page) * MAX_SLOTS + idx;
    if (slot_free_m[k]) return ST_DOUBLE;
    had_no_room = free_head_m[page] == NO_SLOT;
    next_slot_m[k] = free_head_m[page];
    slot_free_m[k] = 1'b1;
    free_head_m[page] = 10'(idx);
    if (slab_used_m[page] > 0) slab_used_m[page]--;
    frees_done++;
    if (had_no_room) partial_m = int'(page);
    remove_live(a);
    freed_objs.push_back(a);
    if (freed_objs.size() > 8) void'(freed_objs.pop_front());
    return ST_OK;
  endfunction

  function automatic int model_reap();
    int i, cnt, p;
    i = 0;
    cnt = 0;
    while (i < order_len) begin
      p = order_m[i];
      if (slab_used_m[p] == 0) begin
        for (int j = i; j + 1 < order_len; j++) order_m[j] = order_m[j+1];
        order_len--;
        slab_live_m[p] = 1'b0;
        cnt++;
        if (partial_m == p) partial_m = first_with_room();
      end else begin
        i++;
      end
    end
    return cnt;
  endfunction

  function automatic alloc_result_t predict_result(logic [2:0] op, logic [47:0] a);
    alloc_result_t r;
    int used;
    r = '0;
    case (op)
      OP_ALLOC: r.status = model_alloc(r.object_address);
      OP_FREE: r.status = model_free(a);
      OP_REAP: r.slab_count = 5'(model_reap());
      OP_STATS: begin
        used = 0;
        for (int i = 0; i < order_len; i++) used += slab_used_m[order_m[i]];
        r.slab_count = 5'(order_len);
        r.objects_used = 13'(used);
        r.objects_total = 13'(order_len * slots_in_slab());
      end
      OP_DESTROY: drop_slabs();
      default: ;
    endcase
    r.alloc_total = allocs_done;
    r.free_total = frees_done;
    return r;
  endfunction

  // Address that is mostly near the pool: headers, misaligned, past the end, freed.
  function automatic logic [47:0] noise_addr();
    logic [63:0] a;
    case ($urandom_range(0, 5))
      0: a = 0;
      1: a = {$urandom, $urandom};
      2: a = 64'(base_addr) + $urandom_range(0, 17) * PAGE_BYTES + $urandom_range(0, 4095);
      3: a = 64'(base_addr) + $urandom_range(0, 15) * PAGE_BYTES + HDR +
             $urandom_range(0, slots_in_slab() + 2) * slot_size();
      4: a = (freed_objs.size() > 0) ?
             64'(freed_objs[$urandom_range(0, freed_objs.size() - 1)]) : 64'(base_addr);
      default: a = 64'(base_addr) - $urandom_range(1, 64);
    endcase
    return a[47:0];
  endfunction

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  // Driver: offers queued items and predicts each one as it is accepted.
  int in_gap = 0;
  always @(posedge clk) begin
    op_item_t it;
    if (!rst_n) begin
      in_tvalid <= 1'b0;
    end else begin
      if (in_tvalid && in_tready) begin
        expected_results.push_back(predict_result(in_tdata[2:0], in_tdata[50:3]));
        accepted++;
      end
      if (!in_tvalid || in_tready) begin
        if (in_gap > 0 || hold_sender || pending_ops.size() == 0) begin
          in_tvalid <= 1'b0;
          if (in_gap > 0) in_gap <= in_gap - 1;
        end else begin
          it = pending_ops.pop_front();
          if (it.kind == ADDR_LIVE && live_objs.size() > 0)
            it.addr = live_objs[$urandom_range(0, live_objs.size() - 1)];
          else if (it.kind != ADDR_FIXED)
            it.addr = noise_addr();
          in_tvalid <= 1'b1;
          in_tdata <= {5'd0, it.addr, it.op};
          in_gap <= pick_gap();
        end
      end
    end
  end

  // Monitor: compares each result item with the oldest prediction; also the watchdog.
  int out_gap = 0, long_left = 0, idle_cycles = 0;
  logic long_done = 1'b0;
  always @(posedge clk) begin
    alloc_result_t got, want;
    if (rst_n) begin
      if (out_tvalid && out_tready) begin
        got = out_tdata[209:0];
        results++;
        if (expected_results.size() == 0) begin
          $display("%0t: unexpected result item %h", $time, got);
          errors++;
        end else begin
          want = expected_results.pop_front();
          status_seen[want.status]++;
          if (got !== want) begin
            $display("%0t: mismatch status %0d/%0d addr %h/%h slabs %0d/%0d", $time,
                     want.status, got.status, want.object_address, got.object_address,
                     want.slab_count, got.slab_count);
            $display("  used %0d/%0d total %0d/%0d allocs %0d/%0d frees %0d/%0d",
                     want.objects_used, got.objects_used, want.objects_total,
                     got.objects_total, want.alloc_total, got.alloc_total,
                     want.free_total, got.free_total);
            errors++;
          end
        end
      end
      if ((out_tvalid && out_tready) || (in_tvalid && in_tready)) idle_cycles = 0;
      else idle_cycles++;
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("%0t: timeout with %0d results outstanding", $time, expected_results.size());
        $display("Verification failed");
        $finish;
      end
      // Receiver side: random gaps plus one long hold-off.
      if (long_stall_req && !long_done) begin
        long_done <= 1'b1;
        long_left <= 300;
        out_tready <= 1'b0;
      end else if (long_left > 0) begin
        long_left <= long_left - 1;
        out_tready <= (long_left == 1);
      end else if (out_gap > 0) begin
        out_gap <= out_gap - 1;
        out_tready <= (out_gap == 1);
      end else begin
        out_gap <= pick_gap();
        out_tready <= 1'b1;
      end
    end
  end

  task automatic queue_op(logic [2:0] op, logic [47:0] a, addr_kind_t k);
    op_item_t it;
    it.op = op;
    it.addr = a;
    it.kind = k;
    pending_ops.push_back(it);
  endtask

  task automatic wait_idle();
    while (pending_ops.size() != 0 || in_tvalid || expected_results.size() != 0)
      @(posedge clk);
    repeat (20) @(posedge clk);
  endtask

  task automatic write_cfg(logic idx, logic [47:0] val);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    if (idx == CFG_OSIZE) begin
      req_bytes = val[11:0];
      drop_slabs();
      allocs_done = '0;
      frees_done = '0;
    end else begin
      base_addr = val;
      live_objs.delete();
      freed_objs.delete();
    end
  endtask

  // Random mix: mostly alloc and well-formed frees, some bad frees and others.
  task automatic queue_random(int n);
    int r;
    for (int i = 0; i < n; i++) begin
      r = $urandom_range(0, 99);
      if (r < 45) queue_op(OP_ALLOC, {$urandom, $urandom}, ADDR_FIXED);
      else if (r < 80) queue_op(OP_FREE, '0, ADDR_LIVE);
      else if (r < 89) queue_op(OP_FREE, '0, ADDR_NOISE);
      else if (r < 93) queue_op(OP_REAP, '0, ADDR_NOISE);
      else if (r < 96) queue_op(OP_STATS, '0, ADDR_NOISE);
      else if (r < 98) queue_op(OP_DESTROY, '0, ADDR_NOISE);
      else queue_op(3'($urandom_range(5, 7)), {$urandom, $urandom}, ADDR_FIXED);
    end
  endtask

  logic [11:0] sizes [6] = '{12'd4064, 12'd8, 12'd1, 12'd2000, 12'd100, 12'd24};
  logic [47:0] bases [6] = '{48'h0, 48'hFFFF_FFFF_F000, 48'h1234_5678_9000,
                             48'hFFFF_FFFF_FFFF, 48'h5, 48'h0000_8000_0000};

  initial begin
    req_bytes = 12'd8;
    base_addr = '0;
    drop_slabs();
    allocs_done = '0;
    frees_done = '0;
    for (int i = 0; i < POOL_SLABS * MAX_SLOTS; i++) slot_free_m[i] = 1'b0;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    repeat (2) @(posedge clk);

    for (int ph = 0; ph < 6; ph++) begin
      wait_idle();
      write_cfg(CFG_OSIZE, 48'(sizes[ph]));
      write_cfg(CFG_POOL_BASE, bases[ph]);
      if (ph == 0) begin
        // One slot per slab: exhaust the pool, then walk the error cases.
        for (int i = 0; i < 17; i++) queue_op(OP_ALLOC, '0, ADDR_FIXED);
        queue_op(OP_STATS, '0, ADDR_FIXED);
        queue_op(OP_FREE, 48'd32, ADDR_FIXED);
        queue_op(OP_FREE, 48'd32, ADDR_FIXED);
        queue_op(OP_FREE, 48'd0, ADDR_FIXED);
        queue_op(OP_FREE, 48'd33, ADDR_FIXED);
        queue_op(OP_FREE, 48'd16, ADDR_FIXED);
        queue_op(OP_FREE, 48'(16 * PAGE_BYTES + 32), ADDR_FIXED);
        queue_op(OP_REAP, '0, ADDR_FIXED);
        queue_op(OP_DESTROY, '0, ADDR_FIXED);
        queue_op(3'd7, 48'hFFFF_FFFF_FFFF, ADDR_FIXED);
        queue_op(OP_STATS, '0, ADDR_FIXED);
      end
      queue_random(170);
      if (ph == 1) begin
        long_stall_req <= 1'b1;
        while (pending_ops.size() > 85) @(posedge clk);
        // Sender pauses until everything outstanding has come back.
        hold_sender <= 1'b1;
        @(posedge clk);
        while (in_tvalid || expected_results.size() != 0) @(posedge clk);
        hold_sender <= 1'b0;
      end
    end
    wait_idle();
    repeat (50) @(posedge clk);
    if (expected_results.size() != 0) errors++;
    $display("Run covered %0d items over 6 object sizes and pool bases, %0d results.",
             accepted, results);
    $display("Status counts ok %0d no-page %0d not-owned %0d double %0d misaligned %0d.",
             status_seen[0], status_seen[1], status_seen[2], status_seen[3], status_seen[4]);
    if (errors == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule

// ----- files.f -----
rtl/soa_pkg.sv
rtl/soa_ram.sv
rtl/soa_ctrl.sv
rtl/soa_dp.sv
rtl/slab_object_allocator.sv
dv/slab_object_allocator_tb.sv
